@@ rtl/prap_pkg.sv @@
// Package for the pivot rotator: widths, fixed-point constants and the arctangent table.
package prap_pkg;

    // Number of rotation iterations (one pipeline stage each)
    localparam int ROTATION_STEPS = 24;

    // Field widths
    localparam int CoordW = 32;            // Q16.16 coordinate
    localparam int AngW   = 26;            // Q9.16 degrees
    localparam int RedW   = AngW + 1;      // angle after one wrap step
    localparam int DiffW  = CoordW + 1;    // point minus pivot, exact
    localparam int ProdW  = DiffW + 31;    // difference times gain inverse
    localparam int XyW    = 52;            // rotation datapath, 32 fraction bits plus growth
    localparam int ZW     = 34;            // residual angle, 24 fraction bits
    localparam int RndW   = XyW - 16;      // rotation result back at 16 fraction bits
    localparam int SumW   = RndW + 1;      // rounded result plus pivot

    // Angle limits in Q9.16 degrees
    localparam logic signed [RedW-1:0] DEG90  = 27'sd5898240;
    localparam logic signed [RedW-1:0] DEG180 = 27'sd11796480;
    localparam logic signed [RedW-1:0] DEG360 = 27'sd23592960;

    // round(2^30 / CORDIC gain)
    localparam logic signed [30:0] KINV = 31'sd652032874;

    // Rounding offsets: the gain prescale plain and folded with a negation, and the output round
    localparam logic signed [ProdW-1:0] PRE_RND     = 64'sd8192;
    localparam logic signed [ProdW-1:0] PRE_RND_NEG = 64'sd8193;
    localparam logic signed [XyW-1:0]   OUT_RND     = 52'sd32768;

    // Saturation limits
    localparam logic signed [CoordW-1:0] COORD_MAX = 32'sh7fff_ffff;
    localparam logic signed [CoordW-1:0] COORD_MIN = 32'sh8000_0000;

    // Beat packing
    localparam int InDataW  = 160;
    localparam int OutDataW = 64;

    // Pipeline state carried between stages
    typedef struct packed {
        logic signed [CoordW-1:0] x;
        logic signed [CoordW-1:0] y;
    } coord_t;

    // atan(2^-i) in degrees, 24 fraction bits
    function automatic logic signed [ZW-1:0] atan_deg(input int idx);
        logic signed [ZW-1:0] t;
        case (idx)
            0:  t = 34'sd754974720;
            1:  t = 34'sd445687602;
            2:  t = 34'sd235489088;
            3:  t = 34'sd119537938;
            4:  t = 34'sd60000934;
            5:  t = 34'sd30029717;
            6:  t = 34'sd15018523;
            7:  t = 34'sd7509720;
            8:  t = 34'sd3754917;
            9:  t = 34'sd1877466;
            10: t = 34'sd938734;
            11: t = 34'sd469367;
            12: t = 34'sd234684;
            13: t = 34'sd117342;
            14: t = 34'sd58671;
            15: t = 34'sd29335;
            16: t = 34'sd14668;
            17: t = 34'sd7334;
            18: t = 34'sd3667;
            19: t = 34'sd1833;
            20: t = 34'sd917;
            21: t = 34'sd458;
            22: t = 34'sd229;
            23: t = 34'sd115;
            24: t = 34'sd57;
            25: t = 34'sd29;
            26: t = 34'sd14;
            27: t = 34'sd7;
            28: t = 34'sd4;
            29: t = 34'sd2;
            30: t = 34'sd1;
            default: t = '0;
        endcase
        return t;
    endfunction

endpackage

@@ rtl/point_rotate_about_pivot_core.sv @@
// Top level: pipelined CORDIC rotation of a point about a pivot, in degrees.
//
//  channel | ports                     | beat contents (low bit up)
//  --------+---------------------------+------------------------------------------------
//  input   | s_tvalid s_tready s_tdata | point_x, point_y, pivot_x, pivot_y, angle_deg
//  result  | m_tvalid m_tready m_tdata | rotated_x, rotated_y; m_tuser = clipped
//
//  One beat enters per cycle unless a result is stalled at the output; the stages
//  are wrap, gain multiply, prescale round, one stage per CORDIC iteration, output
//  round, pivot add with clamp. The pipeline advances as one: it holds while a result
//  sits unaccepted in the output register, and s_tready follows that same enable.
//  Reset (aresetn low at a clock edge) clears only the stage valid bits.
module point_rotate_about_pivot_core #(
    parameter int ROTATION_STEPS = prap_pkg::ROTATION_STEPS
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // point_x[31:0], point_y[63:32], pivot_x[95:64], pivot_y[127:96],
    // angle_deg[153:128], zero[159:154]
    input  logic [prap_pkg::InDataW-1:0]  s_tdata,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // rotated_x[31:0], rotated_y[63:32]
    output logic [prap_pkg::OutDataW-1:0] m_tdata,
    // clipped[0]
    output logic [0:0]                    m_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready
);

    localparam int N = ROTATION_STEPS;

    // Whole pipeline moves when the output register is free or being drained
    logic adv;
    assign adv      = ~m_tvalid | m_tready;
    assign s_tready = adv;

    // ---------------- stage 0: differences and first angle wrap ----------------
    logic signed [prap_pkg::CoordW-1:0] in_px, in_py;
    prap_pkg::coord_t                   in_piv;
    logic signed [prap_pkg::RedW-1:0]   in_ang;
    logic signed [prap_pkg::DiffW-1:0]  dx_next, dy_next;
    logic signed [prap_pkg::RedW-1:0]   a1_next;

    assign in_px    = s_tdata[31:0];
    assign in_py    = s_tdata[63:32];
    assign in_piv.x = s_tdata[95:64];
    assign in_piv.y = s_tdata[127:96];
    assign in_ang   = prap_pkg::RedW'(signed'(s_tdata[153:128]));

    always_comb begin
        dx_next = prap_pkg::DiffW'(in_px) - prap_pkg::DiffW'(in_piv.x);
        dy_next = prap_pkg::DiffW'(in_py) - prap_pkg::DiffW'(in_piv.y);
        // bring angle into (-180, 180]
        if (in_ang > prap_pkg::DEG180) begin
            a1_next = in_ang - prap_pkg::DEG360;
        end else if (in_ang <= -prap_pkg::DEG180) begin
            a1_next = in_ang + prap_pkg::DEG360;
        end else begin
            a1_next = in_ang;
        end
    end

    logic                               v0_reg;
    logic signed [prap_pkg::DiffW-1:0]  dx0_reg, dy0_reg;
    logic signed [prap_pkg::RedW-1:0]   a0_reg;
    prap_pkg::coord_t                   piv0_reg;

    // ---------------- stage 1: gain multiply and quadrant fold ----------------
    logic signed [prap_pkg::ProdW-1:0]  px_next, py_next;
    logic signed [prap_pkg::RedW-1:0]   a2;
    logic                               flip_next;
    logic signed [prap_pkg::ZW-1:0]     z1_next;

    always_comb begin
        px_next = prap_pkg::ProdW'(dx0_reg) * prap_pkg::ProdW'(prap_pkg::KINV);
        py_next = prap_pkg::ProdW'(dy0_reg) * prap_pkg::ProdW'(prap_pkg::KINV);
        // fold outer quadrants by 180 deg; the vector is negated instead
        if (a0_reg > prap_pkg::DEG90) begin
            a2        = a0_reg - prap_pkg::DEG180;
            flip_next = 1'b1;
        end else if (a0_reg < -prap_pkg::DEG90) begin
            a2        = a0_reg + prap_pkg::DEG180;
            flip_next = 1'b1;
        end else begin
            a2        = a0_reg;
            flip_next = 1'b0;
        end
        z1_next = prap_pkg::ZW'(a2) <<< 8;
    end

    logic                               v1_reg;
    logic signed [prap_pkg::ProdW-1:0]  px1_reg, py1_reg;
    logic                               flip1_reg;
    logic signed [prap_pkg::ZW-1:0]     z1_reg;
    prap_pkg::coord_t                   piv1_reg;

    // ---------------- stage 2: negate and round the prescaled vector ----------------
    // -p + r == ~p + (r + 1), so negation folds into the rounding add
    logic signed [prap_pkg::ProdW-1:0]  qx, qy;
    logic signed [prap_pkg::XyW-1:0]    x2_next, y2_next;

    always_comb begin
        if (flip1_reg) begin
            qx = ~px1_reg + prap_pkg::PRE_RND_NEG;
            qy = ~py1_reg + prap_pkg::PRE_RND_NEG;
        end else begin
            qx = px1_reg + prap_pkg::PRE_RND;
            qy = py1_reg + prap_pkg::PRE_RND;
        end
        x2_next = prap_pkg::XyW'(qx >>> 14);
        y2_next = prap_pkg::XyW'(qy >>> 14);
    end

    // CORDIC stage registers: index 0 is the prescaled vector, index i+1 follows iteration i
    logic                               cv_reg  [N+1];
    logic signed [prap_pkg::XyW-1:0]    cx_reg  [N+1];
    logic signed [prap_pkg::XyW-1:0]    cy_reg  [N+1];
    logic signed [prap_pkg::ZW-1:0]     cz_reg  [N+1];
    prap_pkg::coord_t                   cp_reg  [N+1];

    // ---------------- CORDIC iterations, one stage each ----------------
    logic signed [prap_pkg::XyW-1:0]    cx_next [N];
    logic signed [prap_pkg::XyW-1:0]    cy_next [N];
    logic signed [prap_pkg::ZW-1:0]     cz_next [N];

    for (genvar i = 0; i < N; i++) begin : g_iter
        always_comb begin
            if (!cz_reg[i][prap_pkg::ZW-1]) begin
                cx_next[i] = cx_reg[i] - (cy_reg[i] >>> i);
                cy_next[i] = cy_reg[i] + (cx_reg[i] >>> i);
                cz_next[i] = cz_reg[i] - prap_pkg::atan_deg(i);
            end else begin
                cx_next[i] = cx_reg[i] + (cy_reg[i] >>> i);
                cy_next[i] = cy_reg[i] - (cx_reg[i] >>> i);
                cz_next[i] = cz_reg[i] + prap_pkg::atan_deg(i);
            end
        end
    end

    // ---------------- output round back to 16 fraction bits ----------------
    logic signed [prap_pkg::XyW-1:0]    tx, ty;
    logic signed [prap_pkg::RndW-1:0]   rx_next, ry_next;

    always_comb begin
        tx      = cx_reg[N] + prap_pkg::OUT_RND;
        ty      = cy_reg[N] + prap_pkg::OUT_RND;
        rx_next = prap_pkg::RndW'(tx >>> 16);
        ry_next = prap_pkg::RndW'(ty >>> 16);
    end

    logic                               vr_reg;
    logic signed [prap_pkg::RndW-1:0]   rx_reg, ry_reg;
    prap_pkg::coord_t                   pr_reg;

    // ---------------- pivot add back and clamp ----------------
    logic signed [prap_pkg::SumW-1:0]   sx, sy;
    logic                               sat_x, sat_y;
    prap_pkg::coord_t                   res_next;

    always_comb begin
        sx = prap_pkg::SumW'(rx_reg) + prap_pkg::SumW'(pr_reg.x);
        sy = prap_pkg::SumW'(ry_reg) + prap_pkg::SumW'(pr_reg.y);
        // in range when all bits above the 32-bit sign agree with it
        sat_x = (sx[prap_pkg::SumW-1:prap_pkg::CoordW-1] != '0) &&
                (sx[prap_pkg::SumW-1:prap_pkg::CoordW-1] != '1);
        sat_y = (sy[prap_pkg::SumW-1:prap_pkg::CoordW-1] != '0) &&
                (sy[prap_pkg::SumW-1:prap_pkg::CoordW-1] != '1);
        if (!sat_x) begin
            res_next.x = sx[prap_pkg::CoordW-1:0];
        end else if (sx[prap_pkg::SumW-1]) begin
            res_next.x = prap_pkg::COORD_MIN;
        end else begin
            res_next.x = prap_pkg::COORD_MAX;
        end
        if (!sat_y) begin
            res_next.y = sy[prap_pkg::CoordW-1:0];
        end else if (sy[prap_pkg::SumW-1]) begin
            res_next.y = prap_pkg::COORD_MIN;
        end else begin
            res_next.y = prap_pkg::COORD_MAX;
        end
    end

    logic                               mv_reg;
    prap_pkg::coord_t                   res_reg;
    logic                               clip_reg;

    // ---------------- valid bits ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            for (int k = 0; k <= N; k++) begin
                cv_reg[k] <= 1'b0;
            end
            vr_reg <= 1'b0;
            mv_reg <= 1'b0;
        end else if (adv) begin
            v0_reg    <= s_tvalid;
            v1_reg    <= v0_reg;
            cv_reg[0] <= v1_reg;
            for (int k = 0; k < N; k++) begin
                cv_reg[k+1] <= cv_reg[k];
            end
            vr_reg <= cv_reg[N];
            mv_reg <= vr_reg;
        end
    end

    // ---------------- payload registers ----------------
    always_ff @(posedge aclk) begin
        if (adv) begin
            dx0_reg   <= dx_next;
            dy0_reg   <= dy_next;
            a0_reg    <= a1_next;
            piv0_reg  <= in_piv;

            px1_reg   <= px_next;
            py1_reg   <= py_next;
            flip1_reg <= flip_next;
            z1_reg    <= z1_next;
            piv1_reg  <= piv0_reg;

            cx_reg[0] <= x2_next;
            cy_reg[0] <= y2_next;
            cz_reg[0] <= z1_reg;
            cp_reg[0] <= piv1_reg;
            for (int k = 0; k < N; k++) begin
                cx_reg[k+1] <= cx_next[k];
                cy_reg[k+1] <= cy_next[k];
                cz_reg[k+1] <= cz_next[k];
                cp_reg[k+1] <= cp_reg[k];
            end

            rx_reg    <= rx_next;
            ry_reg    <= ry_next;
            pr_reg    <= cp_reg[N];

            res_reg   <= res_next;
            clip_reg  <= sat_x | sat_y;
        end
    end

    assign m_tvalid = mv_reg;
    assign m_tdata  = {res_reg.y, res_reg.x};
    assign m_tuser  = clip_reg;

endmodule

@@ rtl/prap_checker.sv @@
// Port-level checker for the pivot rotator, bound to the top level.
module prap_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic [prap_pkg::OutDataW-1:0] m_tdata,
    input logic [0:0]                    m_tuser,
    input logic                          m_tvalid,
    input logic                          m_tready
);

    // No result beat appears right after reset
    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // A stalled result beat holds its contents
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // Input is ready exactly when the result side is not stalled
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready == (!m_tvalid || m_tready))
        else $error("input ready disagrees with result stall");

    // A clipped result has at least one coordinate at a range limit
    a_clip: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |->
            (m_tdata[31:0] == prap_pkg::COORD_MAX) || (m_tdata[31:0] == prap_pkg::COORD_MIN) ||
            (m_tdata[63:32] == prap_pkg::COORD_MAX) || (m_tdata[63:32] == prap_pkg::COORD_MIN))
        else $error("clipped set without a saturated coordinate");

endmodule

bind point_rotate_about_pivot_core prap_checker u_prap_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);
